[rtl/wdc_pkg.sv]
package wdc_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_WINDOW_DEPTH = 64;
  localparam int DEF_SAMPLE_BITS  = 24;

  // Fixed field widths
  localparam int CFG_W    = 7;
  localparam int FACTOR_W = 4;

  // Window limits and classification constants
  localparam int MIN_WINDOW   = 2;
  localparam int MIN_READINGS = 2;
  localparam int MAX_MAG      = 4;

  // Digit width of the shared iterative multiplier
  localparam int DIGIT_W = 16;

  // Request codes
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_FEW = 1'b1;

  typedef logic signed [FACTOR_W-1:0] factor_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_XX,
    ST_ADD_OO,
    ST_ADD_FIN,
    ST_Q_CX,
    ST_Q_D,
    ST_Q_D2,
    ST_Q_CQ,
    ST_Q_SS,
    ST_Q_V,
    ST_Q_CMP,
    ST_Q_OUT
  } state_t;

endpackage

[rtl/wdc_ifs.sv]
interface wdc_req_if #(
  parameter int SAMPLE_BITS = wdc_pkg::DEF_SAMPLE_BITS
) ();
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, req_type, sample, input ready);
  modport sink (input valid, req_type, sample, output ready);
endinterface

interface wdc_res_if ();
  logic             valid;
  logic             ready;
  wdc_pkg::factor_t factor;
  logic             status;

  modport source (output valid, factor, status, input ready);
  modport sink (input valid, factor, status, output ready);
endinterface

[rtl/window_deviation_classifier.sv]
// Sliding-window deviation classifier.
// req channel (valid/ready): req_type 0 adds sample to the window of the last
//   window_size readings, evicting the oldest once the window is full; no beat
//   comes back. req_type 1 classifies sample against the window's mean and
//   variance and returns one beat on the res channel.
// res channel (valid/ready): factor is -4..-1 or 1..4 (negative unless sample is
//   above the mean, magnitude the first standard-deviation band that holds it);
//   status 1 means fewer than two readings are held, and factor is 0 then.
// cfg_wr_en/cfg_wr_data write window_size (clamped to 2..WINDOW_DEPTH) and clear
//   the window. Write only while the block is idle.
// One item at a time; all products but count*x go through one shared multiplier
//   that takes one 16-bit digit per cycle (NDIG digits, 2 at the defaults). An add
//   holds req.ready low while x*x and, once the window is full, old*old are formed
//   and folded in. A query holds it through count*x, d^2, count*sq, sum^2, the
//   band test and the output register load (the only step with fewer than two readings).
// The result sits in an output register: while res.ready is low a finished
//   result waits there and further add beats are still taken; a second query
//   result waits in its final state until the register drains.
// Reset (rst, synchronous) empties the window and sets window_size to 64 (or WINDOW_DEPTH
//   if smaller). The store is not cleared: only entries written since a clear are read.
module window_deviation_classifier #(
  parameter int WINDOW_DEPTH = wdc_pkg::DEF_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = wdc_pkg::DEF_SAMPLE_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [wdc_pkg::CFG_W-1:0] cfg_wr_data,
  wdc_req_if.sink                   req,
  wdc_res_if.source                 res
);

  localparam int LOGD    = $clog2(WINDOW_DEPTH);
  localparam int PTR_W   = LOGD;
  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W   = SAMPLE_BITS + LOGD;
  localparam int SQ_W    = 2 * SAMPLE_BITS + LOGD;
  localparam int CX_W    = SAMPLE_BITS + CNT_W;
  localparam int D2_W    = 2 * SUM_W;
  localparam int PW      = (2 * SUM_W > SQ_W + CNT_W) ? 2 * SUM_W : SQ_W + CNT_W;
  localparam int CMP_W   = PW + 4;
  localparam int DIGIT_W = wdc_pkg::DIGIT_W;
  localparam int NDIG    = (SUM_W + DIGIT_W - 1) / DIGIT_W;
  localparam int B_W     = NDIG * DIGIT_W;
  localparam int A_W     = SQ_W;
  localparam int MP_W    = A_W + DIGIT_W;
  localparam int DG_W    = $clog2(NDIG + 1);
  localparam int RESET_WS = (WINDOW_DEPTH < 64) ? WINDOW_DEPTH : 64;

  wdc_pkg::state_t state, state_next;

  // Window bookkeeping
  logic [CNT_W-1:0] ws;
  logic [CNT_W-1:0] ws_cfg;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] oldest;
  logic [SUM_W-1:0] sum;
  logic [SQ_W-1:0]  sq;

  // Sample store
  logic [SAMPLE_BITS-1:0] mem [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   full;
  logic [PTR_W-1:0]       pos;

  // Per-item registers
  logic [SAMPLE_BITS-1:0] x_r;
  logic [PTR_W-1:0]       pos_r;
  logic                   full_r;
  logic [CX_W-1:0]        cx;
  logic                   neg;
  logic [D2_W-1:0]        d2;
  logic [PW-1:0]          v;

  // Shared multiplier: acc = acc*2^16 + a*digit, top digit of b first
  logic [A_W-1:0]  mul_a, mul_a_in;
  logic [B_W-1:0]  mul_b, mul_b_in;
  logic [PW-1:0]   mul_acc, mul_acc_next;
  logic [MP_W-1:0] mul_prod;
  logic [DG_W-1:0] dig;
  logic            mul_load;
  logic            last_dig;

  // Query datapath
  logic [CX_W-1:0]  sum_ext;
  logic             neg_calc;
  logic [SUM_W-1:0] d_calc;
  logic [CMP_W-1:0] d2_x, v1_x, v4_x, v9_x;
  logic [2:0]       mag;

  // Result register and pending result
  logic             out_valid;
  wdc_pkg::factor_t out_factor;
  logic             out_status;
  wdc_pkg::factor_t res_factor;
  logic             res_status;

  logic req_fire;
  logic out_free;

  assign req.ready  = (state == wdc_pkg::ST_IDLE);
  assign req_fire   = req.valid && req.ready;
  assign res.valid  = out_valid;
  assign res.factor = out_factor;
  assign res.status = out_status;
  assign out_free   = !out_valid || res.ready;

  // Slot for an add: the oldest entry once full, else the next free one
  assign full = (count >= ws);
  assign pos  = full ? oldest : count[PTR_W-1:0];

  always_comb begin
    if (cfg_wr_data < wdc_pkg::CFG_W'(wdc_pkg::MIN_WINDOW)) begin
      ws_cfg = CNT_W'(wdc_pkg::MIN_WINDOW);
    end else if (int'(cfg_wr_data) > WINDOW_DEPTH) begin
      ws_cfg = CNT_W'(WINDOW_DEPTH);
    end else begin
      ws_cfg = CNT_W'(cfg_wr_data);
    end
  end

  assign last_dig     = (dig == DG_W'(NDIG - 1));
  assign mul_prod     = MP_W'(mul_a) * MP_W'(mul_b[B_W-1 -: DIGIT_W]);
  assign mul_acc_next = ((dig == '0) ? '0 : (mul_acc << DIGIT_W)) + PW'(mul_prod);

  // Sign and distance of count*x from the running sum
  assign sum_ext  = CX_W'(sum);
  assign neg_calc = !(cx > sum_ext);
  assign d_calc   = neg_calc ? SUM_W'(sum_ext - cx) : SUM_W'(cx - sum_ext);

  // Band test against v, 4v and 9v
  assign d2_x = CMP_W'(d2);
  assign v1_x = CMP_W'(v);
  assign v4_x = CMP_W'(v) << 2;
  assign v9_x = (CMP_W'(v) << 3) + CMP_W'(v);

  always_comb begin
    if (d2_x < v1_x) begin
      mag = 3'd1;
    end else if (d2_x < v4_x) begin
      mag = 3'd2;
    end else if (d2_x < v9_x) begin
      mag = 3'd3;
    end else begin
      mag = 3'(wdc_pkg::MAX_MAG);
    end
  end

  always_comb begin
    state_next = state;
    mul_load   = 1'b0;
    mul_a_in   = '0;
    mul_b_in   = '0;
    case (state)
      wdc_pkg::ST_IDLE: begin
        if (req_fire) begin
          if (req.req_type == wdc_pkg::REQ_ADD) begin
            state_next = wdc_pkg::ST_ADD_XX;
            mul_load   = 1'b1;
            mul_a_in   = A_W'(req.sample);
            mul_b_in   = B_W'(req.sample);
          end else if (count < CNT_W'(wdc_pkg::MIN_READINGS)) begin
            state_next = wdc_pkg::ST_Q_OUT;
          end else begin
            state_next = wdc_pkg::ST_Q_CX;
          end
        end
      end
      wdc_pkg::ST_ADD_XX: begin
        if (last_dig) begin
          if (full_r) begin
            state_next = wdc_pkg::ST_ADD_OO;
            mul_load   = 1'b1;
            mul_a_in   = A_W'(rd_data);
            mul_b_in   = B_W'(rd_data);
          end else begin
            state_next = wdc_pkg::ST_ADD_FIN;
          end
        end
      end
      wdc_pkg::ST_ADD_OO: begin
        if (last_dig) begin
          state_next = wdc_pkg::ST_ADD_FIN;
        end
      end
      wdc_pkg::ST_ADD_FIN: begin
        state_next = wdc_pkg::ST_IDLE;
      end
      wdc_pkg::ST_Q_CX: begin
        state_next = wdc_pkg::ST_Q_D;
      end
      wdc_pkg::ST_Q_D: begin
        state_next = wdc_pkg::ST_Q_D2;
        mul_load   = 1'b1;
        mul_a_in   = A_W'(d_calc);
        mul_b_in   = B_W'(d_calc);
      end
      wdc_pkg::ST_Q_D2: begin
        if (last_dig) begin
          state_next = wdc_pkg::ST_Q_CQ;
          mul_load   = 1'b1;
          mul_a_in   = sq;
          mul_b_in   = B_W'(count);
        end
      end
      wdc_pkg::ST_Q_CQ: begin
        if (last_dig) begin
          state_next = wdc_pkg::ST_Q_SS;
          mul_load   = 1'b1;
          mul_a_in   = A_W'(sum);
          mul_b_in   = B_W'(sum);
        end
      end
      wdc_pkg::ST_Q_SS: begin
        if (last_dig) begin
          state_next = wdc_pkg::ST_Q_V;
        end
      end
      wdc_pkg::ST_Q_V: begin
        state_next = wdc_pkg::ST_Q_CMP;
      end
      wdc_pkg::ST_Q_CMP: begin
        state_next = wdc_pkg::ST_Q_OUT;
      end
      wdc_pkg::ST_Q_OUT: begin
        if (out_free) begin
          state_next = wdc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wdc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wdc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sample store: read the slot on accept, write the new reading in the next cycle
  always_ff @(posedge clk) begin
    if (req_fire && (req.req_type == wdc_pkg::REQ_ADD)) begin
      rd_data <= mem[pos];
    end
    if ((state == wdc_pkg::ST_ADD_XX) && (dig == '0)) begin
      mem[pos_r] <= x_r;
    end
  end

  // Multiplier sequencing
  always_ff @(posedge clk) begin
    if (mul_load) begin
      mul_a <= mul_a_in;
      mul_b <= mul_b_in;
      dig   <= '0;
    end else begin
      mul_b <= mul_b << DIGIT_W;
      dig   <= dig + DG_W'(1);
    end
    case (state)
      wdc_pkg::ST_ADD_XX, wdc_pkg::ST_ADD_OO, wdc_pkg::ST_Q_D2,
      wdc_pkg::ST_Q_CQ, wdc_pkg::ST_Q_SS: begin
        mul_acc <= mul_acc_next;
      end
      default: begin
        mul_acc <= mul_acc;
      end
    endcase
  end

  // Per-item datapath
  always_ff @(posedge clk) begin
    if (req_fire) begin
      x_r    <= req.sample;
      pos_r  <= pos;
      full_r <= full;
    end
    case (state)
      wdc_pkg::ST_Q_CX: begin
        cx <= CX_W'(count) * CX_W'(x_r);
      end
      wdc_pkg::ST_Q_D: begin
        neg <= neg_calc;
      end
      wdc_pkg::ST_Q_CQ: begin
        if (dig == '0) begin
          d2 <= mul_acc[D2_W-1:0];
        end
      end
      wdc_pkg::ST_Q_SS: begin
        if (dig == '0) begin
          v <= mul_acc;
        end
      end
      wdc_pkg::ST_Q_V: begin
        v <= v - mul_acc;
      end
      default: begin
        v <= v;
      end
    endcase
  end

  // Pending query result
  always_ff @(posedge clk) begin
    if (req_fire && (req.req_type == wdc_pkg::REQ_QUERY)) begin
      res_factor <= '0;
      res_status <= wdc_pkg::STATUS_FEW;
    end else if (state == wdc_pkg::ST_Q_CMP) begin
      res_factor <= neg ? wdc_pkg::FACTOR_W'(0) - wdc_pkg::FACTOR_W'(mag)
                        : wdc_pkg::FACTOR_W'(mag);
      res_status <= wdc_pkg::STATUS_OK;
    end
  end

  // Window state: clear on a config write, advance on each add
  always_ff @(posedge clk) begin
    if (rst) begin
      ws     <= CNT_W'(RESET_WS);
      count  <= '0;
      oldest <= '0;
      sum    <= '0;
      sq     <= '0;
    end else if (cfg_wr_en) begin
      ws     <= ws_cfg;
      count  <= '0;
      oldest <= '0;
      sum    <= '0;
      sq     <= '0;
    end else begin
      case (state)
        wdc_pkg::ST_ADD_XX: begin
          if (dig == '0) begin
            sum <= sum + SUM_W'(x_r) - (full_r ? SUM_W'(rd_data) : '0);
            if (full_r) begin
              if ((CNT_W'(pos_r) + CNT_W'(1)) == ws) begin
                oldest <= '0;
              end else begin
                oldest <= pos_r + PTR_W'(1);
              end
            end else begin
              count <= count + CNT_W'(1);
            end
          end
        end
        wdc_pkg::ST_ADD_OO: begin
          // x*x finished; fold it in while old*old runs
          if (dig == '0) begin
            sq <= sq + mul_acc[SQ_W-1:0];
          end
        end
        wdc_pkg::ST_ADD_FIN: begin
          if (full_r) begin
            sq <= sq - mul_acc[SQ_W-1:0];
          end else begin
            sq <= sq + mul_acc[SQ_W-1:0];
          end
        end
        default: begin
          sq <= sq;
        end
      endcase
    end
  end

  // Output register: load when free, drop valid once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == wdc_pkg::ST_Q_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == wdc_pkg::ST_Q_OUT) && out_free) begin
      out_factor <= res_factor;
      out_status <= res_status;
    end
  end

endmodule

[bench/window_deviation_classifier_tb.sv]
module window_deviation_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_DEPTH = wdc_pkg::DEF_WINDOW_DEPTH;
  localparam int SAMPLE_BITS  = wdc_pkg::DEF_SAMPLE_BITS;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

  // Quiet cycles before a window_size write, counted once nothing is owed.
  // An add produces no beat, so the block may still be folding one in.
  localparam int SETTLE_CYCLES = 24;
  // Cycles to keep watching for stray beats after the last expected one.
  localparam int DRAIN_CYCLES  = 40;
  // Allow far more than the worst case per item.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS   = 150;

  // One entry of the stimulus queue: either a request beat or a window write.
  typedef struct {
    bit                        is_cfg;
    bit                        calm;
    logic                      req_type;
    logic [SAMPLE_BITS-1:0]    sample;
    logic [wdc_pkg::CFG_W-1:0] cfg_val;
    int                        gap;
  } pending_t;

  typedef struct packed {
    wdc_pkg::factor_t factor;
    logic             status;
  } band_t;

  logic clk;
  logic rst = 1'b1;

  // Testbench-side copies of every block input, known from time zero
  logic                      drv_valid    = 1'b0;
  logic                      drv_req_type = wdc_pkg::REQ_ADD;
  logic [SAMPLE_BITS-1:0]    drv_sample   = '0;
  logic                      drv_ready    = 1'b0;
  logic                      cfg_wr_en    = 1'b0;
  logic [wdc_pkg::CFG_W-1:0] cfg_wr_data  = '0;

  wdc_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_if ();
  wdc_res_if res_if ();

  assign req_if.valid    = drv_valid;
  assign req_if.req_type = drv_req_type;
  assign req_if.sample   = drv_sample;
  assign res_if.ready    = drv_ready;

  window_deviation_classifier #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_if),
    .res        (res_if)
  );

  // ---------------------------------------------------------------------
  // Shadow of the window: circular store, head index, fill count and the
  // exact running sum and sum of squares of the readings held.
  // ---------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] win_mem [WINDOW_DEPTH];
  int unsigned            win_size  = WINDOW_DEPTH;
  int unsigned            win_head  = 0;
  int unsigned            win_count = 0;
  logic [63:0]            win_sum   = '0;
  logic [127:0]           win_sqsum = '0;

  pending_t pending_beats[$];
  band_t    expected_bands[$];
  int       mismatch_count = 0;

  // Driver bookkeeping
  pending_t cur_beat;
  bit       presenting  = 1'b0;
  bit       gapping     = 1'b0;
  int       gap_left    = 0;
  int       settle_left = SETTLE_CYCLES;
  // Receiver runs without stalls while the current phase is a calm one
  bit       res_calm    = 1'b0;
  int       stall_left  = 0;
  int       cycle_count = 0;

  function automatic void clear_window();
    win_head  = 0;
    win_count = 0;
    win_sum   = '0;
    win_sqsum = '0;
  endfunction

  // Clamp a written window_size into 2..WINDOW_DEPTH; any write empties it.
  function automatic void set_window_size(logic [wdc_pkg::CFG_W-1:0] val);
    int sz;
    sz = int'(val);
    if (sz < wdc_pkg::MIN_WINDOW) sz = wdc_pkg::MIN_WINDOW;
    if (sz > WINDOW_DEPTH) sz = WINDOW_DEPTH;
    win_size = sz;
    clear_window();
  endfunction

  // Fold one reading in, evicting the oldest once the window is full.
  function automatic void store_reading(logic [SAMPLE_BITS-1:0] x);
    int unsigned  pos;
    logic [127:0] old;
    logic [127:0] xw;
    xw = 128'(x);
    if (win_count >= win_size) begin
      pos       = win_head % win_size;
      old       = 128'(win_mem[pos]);
      win_sum   = win_sum - old[63:0];
      win_sqsum = win_sqsum - old * old;
      win_head  = (pos + 1) % win_size;
      win_count = win_size - 1;
    end else begin
      pos = (win_head + win_count) % win_size;
    end
    win_mem[pos] = x;
    win_sum      = win_sum + xw[63:0];
    win_sqsum    = win_sqsum + xw * xw;
    win_count++;
  endfunction

  // Band of a reading: smallest n in 1..3 with (c*x - S)^2 < n^2*(c*Q - S^2),
  // else 4. Sign is negative unless c*x is strictly above S.
  function automatic band_t classify_reading(logic [SAMPLE_BITS-1:0] x);
    band_t        b;
    logic [127:0] c, s, cx, d, d2, v;
    bit           neg;
    int           mag;
    if (win_count < wdc_pkg::MIN_READINGS) begin
      b.factor = '0;
      b.status = wdc_pkg::STATUS_FEW;
      return b;
    end
    c   = 128'(win_count);
    s   = 128'(win_sum);
    cx  = c * 128'(x);
    neg = !(cx > s);
    d   = neg ? s - cx : cx - s;
    d2  = d * d;
    v   = win_sqsum * c - s * s;
    mag = wdc_pkg::MAX_MAG;
    for (int n = wdc_pkg::MAX_MAG - 1; n >= 1; n--) begin
      if (d2 < v * 128'(n * n)) mag = n;
    end
    b.factor = neg ? wdc_pkg::factor_t'(-mag) : wdc_pkg::factor_t'(mag);
    b.status = wdc_pkg::STATUS_OK;
    return b;
  endfunction

  // Wait before a beat: none in calm phases, otherwise often none, else 0..17.
  function automatic int draw_pause(bit calm);
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return int'($urandom_range(0, 17));
  endfunction

  function automatic void push_request(logic rt, logic [SAMPLE_BITS-1:0] x, bit calm);
    pending_t p;
    p.is_cfg   = 1'b0;
    p.calm     = calm;
    p.req_type = rt;
    p.sample   = x;
    p.cfg_val  = '0;
    p.gap      = draw_pause(calm);
    pending_beats.push_back(p);
  endfunction

  function automatic void push_window(logic [wdc_pkg::CFG_W-1:0] val, bit calm);
    pending_t p;
    p.is_cfg   = 1'b1;
    p.calm     = calm;
    p.req_type = wdc_pkg::REQ_ADD;
    p.sample   = '0;
    p.cfg_val  = val;
    p.gap      = 0;
    pending_beats.push_back(p);
  endfunction

  // Sample near the phase's center, with now and then a wild or extreme one.
  function automatic logic [SAMPLE_BITS-1:0] draw_sample(longint center, longint spread);
    longint v;
    case ($urandom_range(0, 15))
      0:       return SAMPLE_MAX;
      1:       return '0;
      2, 3:    return SAMPLE_BITS'($urandom());
      default: begin
        v = center + longint'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > longint'(SAMPLE_MAX)) v = longint'(SAMPLE_MAX);
        return v[SAMPLE_BITS-1:0];
      end
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Request driver: pop the stimulus queue, hold each beat until taken,
  // and issue window writes only once the block has gone quiet.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : req_driver
    logic                      cfg_pulse;
    logic [wdc_pkg::CFG_W-1:0] cfg_val;
    cfg_pulse = 1'b0;
    cfg_val   = cfg_wr_data;
    if (rst) begin
      presenting  = 1'b0;
      gapping     = 1'b0;
      settle_left = SETTLE_CYCLES;
    end else begin
      // Update the shadow on the accepted beat; a query owes one result.
      if (presenting && req_if.valid && req_if.ready) begin
        if (cur_beat.req_type == wdc_pkg::REQ_QUERY)
          expected_bands.push_back(classify_reading(cur_beat.sample));
        else
          store_reading(cur_beat.sample);
        presenting  = 1'b0;
        settle_left = SETTLE_CYCLES;
      end

      if (!presenting && !gapping && pending_beats.size() != 0) begin
        if (pending_beats[0].is_cfg) begin
          // Hold the write until every result is in and the block settles.
          if (expected_bands.size() != 0) begin
            settle_left = SETTLE_CYCLES;
          end else if (settle_left != 0) begin
            settle_left--;
          end else begin
            cfg_pulse   = 1'b1;
            cfg_val     = pending_beats[0].cfg_val;
            set_window_size(cfg_val);
            res_calm    = pending_beats[0].calm;
            void'(pending_beats.pop_front());
            settle_left = SETTLE_CYCLES;
          end
        end else begin
          cur_beat = pending_beats.pop_front();
          gap_left = cur_beat.gap;
          gapping  = 1'b1;
        end
      end

      // Count down the idle gap; with no gap the next beat follows directly.
      if (gapping) begin
        if (gap_left == 0) begin
          gapping    = 1'b0;
          presenting = 1'b1;
        end else begin
          gap_left--;
        end
      end
    end
    drv_valid    <= presenting;
    drv_req_type <= cur_beat.req_type;
    drv_sample   <= cur_beat.sample;
    cfg_wr_en    <= cfg_pulse;
    cfg_wr_data  <= cfg_val;
  end

  // ---------------------------------------------------------------------
  // Result monitor: compare each taken beat with the oldest expectation,
  // then stall ready for a random pause, none in calm phases.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : res_monitor
    band_t want;
    if (rst) begin
      stall_left = 0;
      drv_ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_bands.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual factor %0d status %0b",
                   $time, res_if.factor, res_if.status);
          mismatch_count++;
        end else begin
          want = expected_bands.pop_front();
          if (res_if.factor !== want.factor) begin
            $display("%0t ns: factor mismatch, expected %0d, actual %0d",
                     $time, want.factor, res_if.factor);
            mismatch_count++;
          end
          if (res_if.status !== want.status) begin
            $display("%0t ns: status mismatch, expected %0b, actual %0b",
                     $time, want.status, res_if.status);
            mismatch_count++;
          end
        end
        stall_left = draw_pause(res_calm);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      drv_ready <= (stall_left == 0);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus: a directed opening, first at the reset window size and then behind
  // window_size writes, then random phases, each behind a window_size write.
  // ---------------------------------------------------------------------
  initial begin
    longint center, spread;
    bit     calm;
    int     fill;

    // Too few readings, with an empty and then a single-entry window
    push_request(wdc_pkg::REQ_QUERY, 24'd5, 1'b0);
    push_request(wdc_pkg::REQ_ADD, 24'd100, 1'b0);
    push_request(wdc_pkg::REQ_QUERY, 24'd100, 1'b0);
    // Extremes of the sample range
    push_request(wdc_pkg::REQ_ADD, '0, 1'b0);
    push_request(wdc_pkg::REQ_ADD, SAMPLE_MAX, 1'b0);
    push_request(wdc_pkg::REQ_QUERY, '0, 1'b0);
    push_request(wdc_pkg::REQ_QUERY, SAMPLE_MAX, 1'b0);
    push_request(wdc_pkg::REQ_QUERY, 24'h7FFFFF, 1'b0);

    // Smallest window: zero variance, then a query right at the mean
    push_window(7'd2, 1'b0);
    push_request(wdc_pkg::REQ_ADD, 24'd1000, 1'b0);
    push_request(wdc_pkg::REQ_ADD, 24'd1000, 1'b0);
    push_request(wdc_pkg::REQ_QUERY, 24'd1000, 1'b0);
    push_request(wdc_pkg::REQ_QUERY, 24'd1001, 1'b0);
    push_request(wdc_pkg::REQ_ADD, 24'd2000, 1'b0);
    push_request(wdc_pkg::REQ_QUERY, 24'd1500, 1'b0);
    push_request(wdc_pkg::REQ_QUERY, 24'd1500, 1'b0);

    // Below-range write clamps to two; eviction on the third add
    push_window(7'd0, 1'b0);
    push_request(wdc_pkg::REQ_ADD, 24'd5, 1'b0);
    push_request(wdc_pkg::REQ_ADD, 24'd7, 1'b0);
    push_request(wdc_pkg::REQ_ADD, 24'd9, 1'b0);
    push_request(wdc_pkg::REQ_QUERY, 24'd8, 1'b0);

    // Above-range write clamps to the depth and empties the window
    push_window(7'd127, 1'b0);
    push_request(wdc_pkg::REQ_QUERY, 24'd1, 1'b0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      calm = (ph % 4 == 2);
      case (ph)
        0:       push_window(7'd64, calm);
        1:       push_window(7'd2, calm);
        2:       push_window(7'd127, calm);
        3:       push_window(7'd1, calm);
        4:       push_window(7'd3, calm);
        default: push_window(wdc_pkg::CFG_W'($urandom_range(wdc_pkg::MIN_WINDOW, WINDOW_DEPTH)),
                             calm);
      endcase
      center = longint'($urandom_range(0, SAMPLE_MAX));
      spread = longint'(1) << $urandom_range(0, 22);
      // Fill the window first so most queries see a full, wrapping window
      fill = int'($urandom_range(0, 40));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i < fill || $urandom_range(0, 99) < 55)
          push_request(wdc_pkg::REQ_ADD, draw_sample(center, spread), calm);
        else
          push_request(wdc_pkg::REQ_QUERY, draw_sample(center, spread), calm);
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Wait out every beat and result, then watch for strays.
    while (pending_beats.size() != 0 || presenting || gapping || expected_bands.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
